/* rtl/bpf_pkg.sv */
// ----------------------------------------------------------------------------
// bpf_pkg
// Types and constants for the bucketed priority FIFO: transfer payloads,
// action and status codes, and default sizes.
// ----------------------------------------------------------------------------
package bpf_pkg;

    // Default sizes
    localparam int LEVELS_DEFAULT          = 8;
    localparam int DEPTH_PER_LEVEL_DEFAULT = 16;

    // Configuration register
    localparam int         CFG_W          = 4;
    localparam logic [3:0] CFG_LEVELS_RST = 4'd8;

    // Action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Input transfer
    typedef struct packed {
        logic               action;
        logic signed [31:0] item_value;
        logic        [7:0]  level;
    } t_in_item;

    // Result transfer
    typedef struct packed {
        logic signed [31:0] out_value;
        logic        [1:0]  status;
    } t_out_item;

endpackage

/* rtl/bucketed_priority_fifo_core.sv */
// ----------------------------------------------------------------------------
// bucketed_priority_fifo_core
// Multi-level priority queue: one bounded FIFO per level, enqueue to a level,
// dequeue the oldest value of the lowest-numbered non-empty level.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload        Notes
//  -------   ---------------------  -------------  ------------------------
//  input     start & !busy          i_item         enqueue or dequeue
//  result    o_valid (one cycle)    o_result       value and status
//  config    i_cfg_we               i_cfg_data     levels_in_use
//
// One item is taken every cycle while busy is low. While an item sits in the
// input register it is decoded and the pointers, counts and storage are
// updated. Its result, with the registered storage read, is held in the
// result register, so o_valid is high in the cycle after the input register
// cycle.
// Reset clears the pointers, fill counts and pipeline valids; stored values
// are not cleared. busy is high during reset and the first cycle after it.
// The receiver cannot stall, so nothing ever backs up.
// ----------------------------------------------------------------------------
module bucketed_priority_fifo_core #(
    parameter int LEVELS          = bpf_pkg::LEVELS_DEFAULT,
    parameter int DEPTH_PER_LEVEL = bpf_pkg::DEPTH_PER_LEVEL_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  bpf_pkg::t_in_item                 i_item,
    output logic                              o_valid,
    output bpf_pkg::t_out_item                o_result,
    input  logic                              i_cfg_we,
    input  logic [bpf_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int PTR_W  = $clog2(DEPTH_PER_LEVEL);
    localparam int CNT_W  = $clog2(DEPTH_PER_LEVEL + 1);
    localparam int MEM_D  = LEVELS * DEPTH_PER_LEVEL;
    localparam int ADDR_W = $clog2(MEM_D);

    // Control and configuration registers
    logic                          r_busy;
    logic [bpf_pkg::CFG_W-1:0]     r_levels;
    logic                          r_in_valid;
    bpf_pkg::t_in_item             r_in;
    logic [PTR_W-1:0]              r_head [LEVELS];
    logic [PTR_W-1:0]              r_tail [LEVELS];
    logic [CNT_W-1:0]              r_count[LEVELS];
    logic [PTR_W-1:0]              n_head [LEVELS];
    logic [PTR_W-1:0]              n_tail [LEVELS];
    logic [CNT_W-1:0]              n_count[LEVELS];
    logic                          r_out_valid;
    bpf_pkg::t_status              r_status;
    logic                          r_deq_ok;
    logic [31:0]                   r_rd_data;

    // Entry storage
    logic [31:0]                   mem [MEM_D];

    // Execute stage decode
    logic                          is_enq;
    logic                          is_deq;
    logic                          lvl_bad;
    logic [LVL_W-1:0]              enq_idx;
    logic                          enq_full;
    logic                          enq_ok;
    logic [LVL_W-1:0]              deq_idx;
    logic                          deq_found;
    logic                          deq_ok;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             rd_addr;
    bpf_pkg::t_status              n_status;

    assign busy = r_busy;

    // Wrap-around pointer increment
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] pos);
        return (pos == PTR_W'(DEPTH_PER_LEVEL - 1)) ? '0 : pos + PTR_W'(1);
    endfunction

    // Busy for one cycle after reset, config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_levels <= bpf_pkg::CFG_LEVELS_RST;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                r_levels <= i_cfg_data;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_in <= i_item;
        end
    end

    // Enqueue checks: range first, then full
    always_comb begin
        is_enq   = r_in_valid && (r_in.action == bpf_pkg::ACT_ENQ);
        is_deq   = r_in_valid && (r_in.action == bpf_pkg::ACT_DEQ);
        lvl_bad  = (r_in.level >= {4'b0, r_levels}) || (32'(r_in.level) >= LEVELS);
        enq_idx  = r_in.level[LVL_W-1:0];
        enq_full = (r_count[enq_idx] == CNT_W'(DEPTH_PER_LEVEL));
        enq_ok   = is_enq && !lvl_bad && !enq_full;
    end

    // Lowest-numbered non-empty level
    always_comb begin
        deq_idx   = '0;
        deq_found = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                deq_idx   = LVL_W'(i);
                deq_found = 1'b1;
            end
        end
        deq_ok = is_deq && deq_found;
    end

    // Storage addresses
    always_comb begin
        wr_addr = ADDR_W'(enq_idx) * ADDR_W'(DEPTH_PER_LEVEL) + ADDR_W'(r_tail[enq_idx]);
        rd_addr = ADDR_W'(deq_idx) * ADDR_W'(DEPTH_PER_LEVEL) + ADDR_W'(r_head[deq_idx]);
    end

    // Result status
    always_comb begin
        n_status = bpf_pkg::ST_OK;
        if (is_enq) begin
            if (lvl_bad) begin
                n_status = bpf_pkg::ST_RANGE;
            end else if (enq_full) begin
                n_status = bpf_pkg::ST_FULL;
            end
        end else if (!deq_found) begin
            n_status = bpf_pkg::ST_EMPTY;
        end
    end

    // Per-level pointer and count updates
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            n_head[i]  = r_head[i];
            n_tail[i]  = r_tail[i];
            n_count[i] = r_count[i];
            if (enq_ok && (enq_idx == LVL_W'(i))) begin
                n_tail[i]  = next_slot(r_tail[i]);
                n_count[i] = r_count[i] + CNT_W'(1);
            end
            if (deq_ok && (deq_idx == LVL_W'(i))) begin
                n_head[i]  = next_slot(r_head[i]);
                n_count[i] = r_count[i] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Storage write and registered read
    always_ff @(posedge i_clk) begin
        if (enq_ok) begin
            mem[wr_addr] <= r_in.item_value;
        end
        if (deq_ok) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_status <= n_status;
            r_deq_ok <= deq_ok;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result.out_value = r_deq_ok ? r_rd_data : 32'sd0;
    assign o_result.status    = r_status;

endmodule
